// ----- rtl/bqd_pkg.sv -----
package bqd_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W = 2;
    localparam int FREQ_W = 32;
    localparam int QF_W   = 16;
    localparam int FS_W   = 24;
    localparam int COEF_W = 32;

    // Internal widths.
    localparam int PHASE_W      = 31;
    localparam int CORDIC_STEPS = 28;
    localparam int CW           = 34;
    localparam int C_W          = 32;
    localparam int ALPHA_W      = 42;
    localparam int MAG_W        = 42;
    localparam int DEN_W        = 43;

    localparam logic [KIND_W-1:0] KIND_LOWPASS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIGHPASS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BANDPASS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd3;

    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam logic [FS_W-1:0] FS_RESET = 24'd48000;

    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30         = 34'sd1073741824;
    localparam logic [MAG_W-1:0]     ONE_Q30_WIDE    = 42'd1073741824;

    // Arctangent of 2^-i as a fraction of a full turn, Q0.32.
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    typedef struct packed {
        logic [KIND_W-1:0] filter_kind;
        logic [FREQ_W-1:0] cutoff_freq;
        logic [QF_W-1:0]   quality_factor;
    } in_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] feed_forward_zero;
        logic signed [COEF_W-1:0] feed_forward_one;
        logic signed [COEF_W-1:0] feed_forward_two;
        logic signed [COEF_W-1:0] feedback_one;
        logic signed [COEF_W-1:0] feedback_two;
        logic                     design_status;
    } out_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              reject;
        logic [QF_W-1:0]   qf;
    } phase_tag_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              reject;
        logic              swap;
        logic [QF_W-1:0]   qf;
    } cordic_tag_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic                  reject;
        logic signed [C_W-1:0] c;
    } alpha_tag_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              reject;
        logic              neg;
    } coef_tag_t;

endpackage

// ----- rtl/bqd_div_cell.sv -----
// One restoring division step: shifts in one numerator bit and yields one
// quotient bit, then hands everything to the next cell.
module bqd_div_cell #(
    parameter int RW = 24,
    parameter int NW = 31,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          vld_in,
    input  logic [SW-1:0] tag_in,
    input  logic [RW-1:0] rem_in,
    input  logic [RW-1:0] den_in,
    input  logic [NW-1:0] num_in,
    input  logic [QW-1:0] quo_in,
    output logic          vld_out,
    output logic [SW-1:0] tag_out,
    output logic [RW-1:0] rem_out,
    output logic [RW-1:0] den_out,
    output logic [NW-1:0] num_out,
    output logic [QW-1:0] quo_out
);

    logic [RW:0]   trial;
    logic          fits;
    logic [RW:0]   diff;
    logic [RW-1:0] rem_next;
    logic [NW-1:0] num_next;
    logic [QW-1:0] quo_next;

    logic          vld_reg;
    logic [SW-1:0] tag_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] den_reg;
    logic [NW-1:0] num_reg;
    logic [QW-1:0] quo_reg;

    always_comb begin
        trial    = {rem_in, num_in[NW-1]};
        fits     = trial >= {1'b0, den_in};
        diff     = trial - {1'b0, den_in};
        rem_next = fits ? diff[RW-1:0] : trial[RW-1:0];
        num_next = {num_in[NW-2:0], 1'b0};
        quo_next = {quo_in[QW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg <= tag_in;
            rem_reg <= rem_next;
            den_reg <= den_in;
            num_reg <= num_next;
            quo_reg <= quo_next;
        end
    end

    assign vld_out = vld_reg;
    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;

endmodule

// ----- rtl/bqd_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation with floor shifts.
module bqd_cordic_cell
    import bqd_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [SW-1:0]        tag_in,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic                 vld_out,
    output logic [SW-1:0]        tag_out,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);

    logic signed [CW-1:0] atan_step;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;

    logic                 vld_reg;
    logic [SW-1:0]        tag_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;

    assign atan_step = signed'({2'b00, ATAN_TURNS[STEP]});

    always_comb begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!z_in[CW-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_step;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg <= tag_in;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign vld_out = vld_reg;
    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ----- rtl/biquad_coefficient_designer.sv -----
// Throughput: one transaction per cycle; the whole chain of cells advances together
// and halts only while a finished result waits on m_ready.
// Reset (aresetn low, synchronous) empties every cell and the output register and
// sets the sample rate to 48000 Hz.
module biquad_coefficient_designer
    import bqd_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [FS_W-1:0] cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_item_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data
);

    // The design is a row of cells in four sections. The phase divider forms
    // floor(fc * 2^24 / fs) one quotient bit per cell. The CORDIC section turns
    // that phase into cosine and sine, one micro-rotation per cell. The alpha
    // divider forms round(s * 2048 / q), again one bit per cell. Finally four
    // parallel coefficient lanes divide the numerators by a0 (or 2*a0) with one extra
    // fraction bit, which the output stage uses for rounding.

    localparam int PD_STEPS = PHASE_W;
    localparam int AD_STEPS = ALPHA_W;
    localparam int CQ_W     = COEF_FRAC_BITS + 3;
    localparam int LANES    = 4;

    // Advance the whole row whenever the output register is free or being read.
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Sample rate register.
    logic [FS_W-1:0] fs_reg;
    logic [FS_W-1:0] fs_next;

    always_comb begin
        fs_next = cfg_we ? cfg_wdata : fs_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg <= FS_RESET;
        end else begin
            fs_reg <= fs_next;
        end
    end

    // Screening of the request. A cutoff at or above Nyquist is detected as
    // 2*fc >= 256*fs, both sides in 33 bits; a zero sample rate fails it too.
    logic       in_reject;
    logic [32:0] twice_fc;
    logic [32:0] nyq_limit;

    always_comb begin
        twice_fc  = {s_data.cutoff_freq, 1'b0};
        nyq_limit = {1'b0, fs_reg, 8'b0};
        in_reject = (s_data.filter_kind == KIND_UNKNOWN) ||
                    (s_data.quality_factor == '0) ||
                    (s_data.cutoff_freq == '0) ||
                    (twice_fc >= nyq_limit);
    end

    // ---------------------------------------------------------------------
    // Phase divider. Because fc < 128*fs for an accepted request, fc >> 7 is
    // already below fs and the quotient needs only 31 bits.
    // ---------------------------------------------------------------------
    logic                pd_vld [0:PD_STEPS];
    phase_tag_t          pd_tag [0:PD_STEPS];
    logic [FS_W-1:0]     pd_rem [0:PD_STEPS];
    logic [FS_W-1:0]     pd_den [0:PD_STEPS];
    logic [PHASE_W-1:0]  pd_num [0:PD_STEPS];
    logic [PHASE_W-1:0]  pd_quo [0:PD_STEPS];

    always_comb begin
        pd_vld[0]        = s_valid;
        pd_tag[0].kind   = s_data.filter_kind;
        pd_tag[0].reject = in_reject;
        pd_tag[0].qf     = s_data.quality_factor;
        pd_rem[0]        = s_data.cutoff_freq[30:7];
        pd_den[0]        = fs_reg;
        pd_num[0]        = {s_data.cutoff_freq[6:0], 24'b0};
        pd_quo[0]        = '0;
    end

    for (genvar i = 0; i < PD_STEPS; i++) begin : g_phase
        bqd_div_cell #(
            .RW(FS_W), .NW(PHASE_W), .QW(PHASE_W), .SW($bits(phase_tag_t))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (pd_vld[i]),
            .tag_in  (pd_tag[i]),
            .rem_in  (pd_rem[i]),
            .den_in  (pd_den[i]),
            .num_in  (pd_num[i]),
            .quo_in  (pd_quo[i]),
            .vld_out (pd_vld[i+1]),
            .tag_out (pd_tag[i+1]),
            .rem_out (pd_rem[i+1]),
            .den_out (pd_den[i+1]),
            .num_out (pd_num[i+1]),
            .quo_out (pd_quo[i+1])
        );
    end

    // ---------------------------------------------------------------------
    // CORDIC. A phase of a quarter turn or more loses that quarter turn, and
    // the swap flag later exchanges the results as cos = -sin', sin = cos'.
    // ---------------------------------------------------------------------
    logic                 cr_vld [0:CORDIC_STEPS];
    cordic_tag_t          cr_tag [0:CORDIC_STEPS];
    logic signed [CW-1:0] cr_x   [0:CORDIC_STEPS];
    logic signed [CW-1:0] cr_y   [0:CORDIC_STEPS];
    logic signed [CW-1:0] cr_z   [0:CORDIC_STEPS];

    always_comb begin
        cr_vld[0]        = pd_vld[PD_STEPS];
        cr_tag[0].kind   = pd_tag[PD_STEPS].kind;
        cr_tag[0].reject = pd_tag[PD_STEPS].reject;
        cr_tag[0].swap   = pd_quo[PD_STEPS][PHASE_W-1];
        cr_tag[0].qf     = pd_tag[PD_STEPS].qf;
        cr_x[0]          = CORDIC_GAIN_INV;
        cr_y[0]          = '0;
        cr_z[0]          = signed'({4'b0, pd_quo[PD_STEPS][PHASE_W-2:0]});
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        bqd_cordic_cell #(
            .STEP(i), .SW($bits(cordic_tag_t))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (cr_vld[i]),
            .tag_in  (cr_tag[i]),
            .x_in    (cr_x[i]),
            .y_in    (cr_y[i]),
            .z_in    (cr_z[i]),
            .vld_out (cr_vld[i+1]),
            .tag_out (cr_tag[i+1]),
            .x_out   (cr_x[i+1]),
            .y_out   (cr_y[i+1]),
            .z_out   (cr_z[i+1])
        );
    end

    // Quadrant fix-up and clamping: c to [-1, 1] and s to [0, 1] in Q2.30.
    // The alpha numerator is s * 2048 plus half of q, so the floor division
    // that follows rounds to nearest with ties up.
    logic signed [CW-1:0] cos_raw;
    logic signed [CW-1:0] sin_raw;
    logic signed [CW-1:0] cos_clamped;
    logic signed [CW-1:0] sin_clamped;
    logic [ALPHA_W-1:0]   alpha_num;

    always_comb begin
        if (cr_tag[CORDIC_STEPS].swap) begin
            cos_raw = -cr_y[CORDIC_STEPS];
            sin_raw = cr_x[CORDIC_STEPS];
        end else begin
            cos_raw = cr_x[CORDIC_STEPS];
            sin_raw = cr_y[CORDIC_STEPS];
        end
        if (cos_raw > ONE_Q30) begin
            cos_clamped = ONE_Q30;
        end else if (cos_raw < -ONE_Q30) begin
            cos_clamped = -ONE_Q30;
        end else begin
            cos_clamped = cos_raw;
        end
        if (sin_raw > ONE_Q30) begin
            sin_clamped = ONE_Q30;
        end else if (sin_raw < 0) begin
            sin_clamped = '0;
        end else begin
            sin_clamped = sin_raw;
        end
        alpha_num = {sin_clamped[30:0], 11'b0} +
                    {{(ALPHA_W - QF_W + 1){1'b0}}, cr_tag[CORDIC_STEPS].qf[QF_W-1:1]};
    end

    // ---------------------------------------------------------------------
    // Alpha divider: 42 quotient bits, remainder below q.
    // ---------------------------------------------------------------------
    logic               ad_vld [0:AD_STEPS];
    alpha_tag_t         ad_tag [0:AD_STEPS];
    logic [QF_W-1:0]    ad_rem [0:AD_STEPS];
    logic [QF_W-1:0]    ad_den [0:AD_STEPS];
    logic [ALPHA_W-1:0] ad_num [0:AD_STEPS];
    logic [ALPHA_W-1:0] ad_quo [0:AD_STEPS];

    always_comb begin
        ad_vld[0]        = cr_vld[CORDIC_STEPS];
        ad_tag[0].kind   = cr_tag[CORDIC_STEPS].kind;
        ad_tag[0].reject = cr_tag[CORDIC_STEPS].reject;
        ad_tag[0].c      = C_W'(cos_clamped);
        ad_rem[0]        = '0;
        ad_den[0]        = cr_tag[CORDIC_STEPS].qf;
        ad_num[0]        = alpha_num;
        ad_quo[0]        = '0;
    end

    for (genvar i = 0; i < AD_STEPS; i++) begin : g_alpha
        bqd_div_cell #(
            .RW(QF_W), .NW(ALPHA_W), .QW(ALPHA_W), .SW($bits(alpha_tag_t))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (ad_vld[i]),
            .tag_in  (ad_tag[i]),
            .rem_in  (ad_rem[i]),
            .den_in  (ad_den[i]),
            .num_in  (ad_num[i]),
            .quo_in  (ad_quo[i]),
            .vld_out (ad_vld[i+1]),
            .tag_out (ad_tag[i+1]),
            .rem_out (ad_rem[i+1]),
            .den_out (ad_den[i+1]),
            .num_out (ad_num[i+1]),
            .quo_out (ad_quo[i+1])
        );
    end

    // ---------------------------------------------------------------------
    // Coefficient numerators. Lane 0 gives b0, lane 1 gives b1, lane 2 gives
    // a1 and lane 3 gives a2; b2 is derived from b0 at the output. Every
    // quotient is at most 2, so starting the remainder at mag >> 2 is safe.
    // ---------------------------------------------------------------------
    logic [ALPHA_W-1:0]   alpha;
    logic [ALPHA_W-1:0]   a0;
    logic [DEN_W-1:0]     den_a0;
    logic [DEN_W-1:0]     den_2a0;
    logic signed [CW-1:0] c_ext;
    logic signed [CW-1:0] one_minus_c;
    logic signed [CW-1:0] one_plus_c;
    logic signed [CW-1:0] twice_c;
    logic signed [CW-1:0] abs_twice_c;
    logic [MAG_W-1:0]     lane_mag [0:LANES-1];
    logic [DEN_W-1:0]     lane_den [0:LANES-1];
    logic                 lane_neg [0:LANES-1];
    logic [KIND_W-1:0]    set_kind;

    always_comb begin
        set_kind    = ad_tag[AD_STEPS].kind;
        alpha       = ad_quo[AD_STEPS];
        a0          = ONE_Q30_WIDE + alpha;
        den_a0      = {1'b0, a0};
        den_2a0     = {a0, 1'b0};
        c_ext       = CW'(ad_tag[AD_STEPS].c);
        one_minus_c = ONE_Q30 - c_ext;
        one_plus_c  = ONE_Q30 + c_ext;
        twice_c     = c_ext <<< 1;
        abs_twice_c = twice_c[CW-1] ? -twice_c : twice_c;

        unique case (set_kind)
            KIND_LOWPASS: begin
                lane_mag[0] = MAG_W'(unsigned'(one_minus_c));
                lane_den[0] = den_2a0;
                lane_neg[0] = 1'b0;
                lane_mag[1] = MAG_W'(unsigned'(one_minus_c));
                lane_neg[1] = 1'b0;
            end
            KIND_HIGHPASS: begin
                lane_mag[0] = MAG_W'(unsigned'(one_plus_c));
                lane_den[0] = den_2a0;
                lane_neg[0] = 1'b0;
                lane_mag[1] = MAG_W'(unsigned'(one_plus_c));
                lane_neg[1] = 1'b1;
            end
            default: begin
                lane_mag[0] = alpha;
                lane_den[0] = den_a0;
                lane_neg[0] = 1'b0;
                lane_mag[1] = '0;
                lane_neg[1] = 1'b0;
            end
        endcase
        lane_den[1] = den_a0;

        lane_mag[2] = MAG_W'(unsigned'(abs_twice_c));
        lane_den[2] = den_a0;
        lane_neg[2] = (c_ext > 0);

        if (alpha > ONE_Q30_WIDE) begin
            lane_mag[3] = alpha - ONE_Q30_WIDE;
            lane_neg[3] = 1'b1;
        end else begin
            lane_mag[3] = ONE_Q30_WIDE - alpha;
            lane_neg[3] = 1'b0;
        end
        lane_den[3] = den_a0;
    end

    // ---------------------------------------------------------------------
    // Coefficient lanes: COEF_FRAC_BITS + 3 quotient bits each.
    // ---------------------------------------------------------------------
    logic             cl_vld [0:LANES-1][0:CQ_W];
    coef_tag_t        cl_tag [0:LANES-1][0:CQ_W];
    logic [DEN_W-1:0] cl_rem [0:LANES-1][0:CQ_W];
    logic [DEN_W-1:0] cl_den [0:LANES-1][0:CQ_W];
    logic [CQ_W-1:0]  cl_num [0:LANES-1][0:CQ_W];
    logic [CQ_W-1:0]  cl_quo [0:LANES-1][0:CQ_W];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_comb begin
            cl_vld[l][0]        = ad_vld[AD_STEPS];
            cl_tag[l][0].kind   = set_kind;
            cl_tag[l][0].reject = ad_tag[AD_STEPS].reject;
            cl_tag[l][0].neg    = lane_neg[l];
            cl_rem[l][0]        = DEN_W'(lane_mag[l] >> 2);
            cl_den[l][0]        = lane_den[l];
            cl_num[l][0]        = {lane_mag[l][1:0], {(COEF_FRAC_BITS + 1){1'b0}}};
            cl_quo[l][0]        = '0;
        end

        for (genvar i = 0; i < CQ_W; i++) begin : g_step
            bqd_div_cell #(
                .RW(DEN_W), .NW(CQ_W), .QW(CQ_W), .SW($bits(coef_tag_t))
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .vld_in  (cl_vld[l][i]),
                .tag_in  (cl_tag[l][i]),
                .rem_in  (cl_rem[l][i]),
                .den_in  (cl_den[l][i]),
                .num_in  (cl_num[l][i]),
                .quo_in  (cl_quo[l][i]),
                .vld_out (cl_vld[l][i+1]),
                .tag_out (cl_tag[l][i+1]),
                .rem_out (cl_rem[l][i+1]),
                .den_out (cl_den[l][i+1]),
                .num_out (cl_num[l][i+1]),
                .quo_out (cl_quo[l][i+1])
            );
        end
    end

    // Rounds the quotient with its extra fraction bit (ties away from zero),
    // applies the sign and saturates to 32 bits.
    function automatic logic [COEF_W-1:0] finish_coef(input logic [CQ_W-1:0] q,
                                                      input logic neg);
        logic [CQ_W:0]  r;
        logic [33:0]    rw;
        logic [33:0]    rn;
        logic [COEF_W-1:0] res;
        r  = ({1'b0, q} + {{CQ_W{1'b0}}, 1'b1}) >> 1;
        rw = 34'(r);
        rn = 34'd0 - rw;
        if (neg) begin
            res = (rw > 34'h080000000) ? 32'h80000000 : rn[COEF_W-1:0];
        end else begin
            res = (rw > 34'h07FFFFFFF) ? 32'h7FFFFFFF : rw[COEF_W-1:0];
        end
        return res;
    endfunction

    // Output register.
    out_item_t m_data_reg;
    out_item_t m_data_next;
    logic [COEF_W-1:0] lane_res [0:LANES-1];
    logic [COEF_W-1:0] b0_neg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_res[l] = finish_coef(cl_quo[l][CQ_W], cl_tag[l][CQ_W].neg);
        end
        b0_neg = 32'd0 - lane_res[0];

        if (cl_tag[0][CQ_W].reject) begin
            m_data_next                   = '0;
            m_data_next.design_status     = STATUS_REJECTED;
        end else begin
            m_data_next.feed_forward_zero = lane_res[0];
            m_data_next.feedback_one      = lane_res[2];
            m_data_next.feedback_two      = lane_res[3];
            m_data_next.design_status     = STATUS_ACCEPTED;
            if (cl_tag[0][CQ_W].kind == KIND_BANDPASS) begin
                m_data_next.feed_forward_one = '0;
                m_data_next.feed_forward_two = b0_neg;
            end else begin
                m_data_next.feed_forward_one = lane_res[1];
                m_data_next.feed_forward_two = lane_res[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cl_vld[0][CQ_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- dv/biquad_coefficient_designer_tb.sv -----
module biquad_coefficient_designer_tb;
    import bqd_pkg::*;

    // The block is built with its default of 28 fraction bits; the predictor below uses the same.
    localparam int FRAC_BITS = 28;
    localparam int LATENCY = FRAC_BITS + 105;
    localparam longint CYCLE_LIMIT = 2000000;

    localparam longint ONE_Q30_L = 64'sd1073741824;
    localparam longint QUARTER = 64'd1073741824;
    localparam longint GAIN_INV = 64'sd652032874;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [FS_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    biquad_coefficient_designer dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // The clock runs with a period of 20 time units.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Pending design requests, the coefficients we expect back, and the sample rate the
    // predictor currently assumes.
    in_item_t request_q[$];
    out_item_t coef_q[$];
    logic [FS_W-1:0] model_fs;
    int error_count = 0;
    longint cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The ready seen at the last rising edge, which is what decided acceptance there.
    logic s_ready_seen = 1'b0;

    // Floor shift of a signed value; SystemVerilog's arithmetic shift already floors.
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    // Rotation-mode CORDIC over an angle below a quarter turn, in turns (Q0.32).
    function automatic void cordic_rotate(input longint angle, output longint cs,
                                          output longint sn);
        longint x, y, z, dx, dy;
        int i;
        x = GAIN_INV;
        y = 0;
        z = angle;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        cs = x;
        sn = y;
    endfunction

    // Rounded quotient num * 2^FRAC_BITS / den, ties away from zero, saturated to 32 bits.
    function automatic logic signed [COEF_W-1:0] scaled_ratio(input longint num,
                                                               input longint unsigned den);
        logic neg;
        longint unsigned mag, quo, rem;
        int i;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        quo = mag / den;
        rem = mag % den;
        for (i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem -= den;
                quo |= 1;
            end
        end
        if ((rem << 1) >= den)
            quo += 1;
        if (neg)
            return (quo > 64'd2147483648) ? 32'sh8000_0000 : 32'(-(longint'(quo)));
        return (quo > 64'd2147483647) ? 32'sh7fff_ffff : quo[31:0];
    endfunction

    // Works out the normalised biquad coefficients for one request.
    function automatic out_item_t design_biquad(input in_item_t req, input logic [FS_W-1:0] fs);
        out_item_t r;
        longint unsigned fc, qf, phase, alpha, a0;
        longint c, s, cp, sp, al, omc, opc;
        r = '0;
        fc = 64'(req.cutoff_freq);
        qf = 64'(req.quality_factor);
        if (req.filter_kind == KIND_UNKNOWN || qf == 0 || fc == 0 ||
            2 * fc >= 256 * longint'(fs)) begin
            r.design_status = STATUS_REJECTED;
            return r;
        end
        phase = (fc << 24) / fs;
        if (phase >= QUARTER) begin
            cordic_rotate(phase - QUARTER, cp, sp);
            c = -sp;
            s = cp;
        end else begin
            cordic_rotate(phase, c, s);
        end
        if (c > ONE_Q30_L) c = ONE_Q30_L;
        if (c < -ONE_Q30_L) c = -ONE_Q30_L;
        if (s > ONE_Q30_L) s = ONE_Q30_L;
        if (s < 0) s = 0;
        alpha = (s * 2048 + qf / 2) / qf;
        a0 = ONE_Q30_L + alpha;
        al = alpha;
        omc = ONE_Q30_L - c;
        opc = ONE_Q30_L + c;
        case (req.filter_kind)
            KIND_LOWPASS: begin
                r.feed_forward_zero = scaled_ratio(omc, 2 * a0);
                r.feed_forward_one = scaled_ratio(omc, a0);
                r.feed_forward_two = r.feed_forward_zero;
            end
            KIND_HIGHPASS: begin
                r.feed_forward_zero = scaled_ratio(opc, 2 * a0);
                r.feed_forward_one = scaled_ratio(-opc, a0);
                r.feed_forward_two = r.feed_forward_zero;
            end
            default: begin
                r.feed_forward_zero = scaled_ratio(al, a0);
                r.feed_forward_one = '0;
                r.feed_forward_two = scaled_ratio(-al, a0);
            end
        endcase
        r.feedback_one = scaled_ratio(-2 * c, a0);
        r.feedback_two = scaled_ratio(ONE_Q30_L - al, a0);
        r.design_status = STATUS_ACCEPTED;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [COEF_W-1:0] got,
                                   input logic [COEF_W-1:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    // Driver: inputs change on the falling edge. The prediction is made when the transaction
    // is accepted, so the rising edge before this falling edge is the point of acceptance.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_seen) begin
                coef_q.push_back(design_biquad(s_data, model_fs));
                void'(request_q.pop_front());
            end
            if (!(s_valid && !s_ready_seen)) begin
                if (request_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= request_q[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Monitor: outputs are sampled on the rising edge, one transaction per valid and ready.
    always @(posedge aclk) begin
        out_item_t want;
        cycle_count <= cycle_count + 1;
        s_ready_seen <= s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (coef_q.size() == 0) begin
                $display("coefficient transaction arrived with none outstanding");
                error_count++;
            end else begin
                want = coef_q.pop_front();
                if (m_data.feed_forward_zero !== want.feed_forward_zero)
                    report_mismatch("b0", m_data.feed_forward_zero, want.feed_forward_zero);
                if (m_data.feed_forward_one !== want.feed_forward_one)
                    report_mismatch("b1", m_data.feed_forward_one, want.feed_forward_one);
                if (m_data.feed_forward_two !== want.feed_forward_two)
                    report_mismatch("b2", m_data.feed_forward_two, want.feed_forward_two);
                if (m_data.feedback_one !== want.feedback_one)
                    report_mismatch("a1", m_data.feedback_one, want.feedback_one);
                if (m_data.feedback_two !== want.feedback_two)
                    report_mismatch("a2", m_data.feedback_two, want.feedback_two);
                if (m_data.design_status !== want.design_status)
                    report_mismatch("status", 32'(m_data.design_status),
                                    32'(want.design_status));
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[biquad_coefficient_designer] ERROR");
            $finish;
        end
    end

    // A random request, mostly in band for the current sample rate.
    function automatic in_item_t random_request(input logic [FS_W-1:0] fs);
        in_item_t r;
        longint unsigned nyq;
        int pick;
        nyq = longint'(fs) * 128;
        pick = $urandom_range(99, 0);
        r.filter_kind = (pick < 6) ? KIND_UNKNOWN : 2'($urandom_range(2, 0));
        if (pick < 80 && nyq > 1)
            r.cutoff_freq = 32'(1 + ({$urandom, $urandom} % (nyq - 1)));
        else
            r.cutoff_freq = $urandom;
        case ($urandom_range(9, 0))
            0: r.quality_factor = 16'($urandom_range(1, 0));
            1: r.quality_factor = 16'hffff - 16'($urandom_range(3, 0));
            2: r.quality_factor = 16'($urandom_range(4096, 1));
            default: r.quality_factor = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic queue_directed(input logic [FS_W-1:0] fs);
        in_item_t r;
        longint unsigned nyq;
        int k;
        nyq = longint'(fs) * 128;
        for (k = 0; k < 4; k++) begin
            r.filter_kind = 2'(k);
            r.cutoff_freq = 32'(nyq / 4);
            r.quality_factor = 16'd2896;
            request_q.push_back(r);
        end
        for (k = 0; k < 3; k++) begin
            r.filter_kind = 2'(k);
            // Just inside the band at both ends, then exactly at Nyquist.
            r.cutoff_freq = 32'd1;
            r.quality_factor = 16'hffff;
            request_q.push_back(r);
            r.cutoff_freq = (nyq > 32'hffffffff) ? 32'hffffffff : 32'(nyq - 1);
            r.quality_factor = 16'd1;
            request_q.push_back(r);
            r.cutoff_freq = (nyq > 32'hffffffff) ? 32'hffffffff : 32'(nyq);
            request_q.push_back(r);
            // Zero cutoff and zero q are both rejected.
            r.cutoff_freq = 32'd0;
            r.quality_factor = 16'd4096;
            request_q.push_back(r);
            r.cutoff_freq = 32'(nyq / 3);
            r.quality_factor = 16'd0;
            request_q.push_back(r);
        end
        r.filter_kind = KIND_BANDPASS;
        r.cutoff_freq = 32'hffffffff;
        r.quality_factor = 16'h8000;
        request_q.push_back(r);
    endtask

    // Waits for the block to drain, then lets its latency pass before the next write.
    task automatic drain_block;
        wait (request_q.size() == 0 && coef_q.size() == 0);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    task automatic write_sample_rate(input logic [FS_W-1:0] fs);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= fs;
        @(negedge aclk);
        cfg_we <= 1'b0;
        model_fs = fs;
    endtask

    initial begin
        logic [FS_W-1:0] rates[6];
        int p, n;
        model_fs = FS_RESET;
        rates = '{24'd48000, 24'd1, 24'hffffff, 24'd44100, 24'd8000, 24'd2};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        // The reset sample rate is exercised before the first register write.
        queue_directed(model_fs);
        drain_block();
        for (p = 0; p < 6; p++) begin
            write_sample_rate(rates[p]);
            // Idling pattern: none, sender, receiver, both, then repeat.
            case (p % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 46; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 46; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (p == 1 || p == 2)
                queue_directed(model_fs);
            for (n = 0; n < 290; n++)
                request_q.push_back(random_request(model_fs));
            drain_block();
        end
        if (error_count == 0) begin
            $display("[biquad_coefficient_designer] OK");
        end else begin
            $display("[biquad_coefficient_designer] ERROR");
        end
        $finish;
    end

endmodule
